>>> sv/psi_pkg.sv
`timescale 1ns / 1ps

package psi_pkg;

  localparam int unsigned HALF_SPAN       = 16;
  localparam int unsigned NTAPS           = 2 * HALF_SPAN + 1;
  localparam int unsigned MAX_FACTOR      = 16;
  localparam int unsigned FACTOR_LOG2_MAX = $clog2(MAX_FACTOR);
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned COEF_W          = 18;
  localparam int unsigned COEF_FRAC       = COEF_W - 2;
  localparam int unsigned PROD_W          = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W           = PROD_W + $clog2(NTAPS);
  localparam int unsigned TAP_DEPTH       = MAX_FACTOR * NTAPS;
  localparam int unsigned TAP_AW          = $clog2(TAP_DEPTH);
  localparam int unsigned TAP_CNT_W       = $clog2(NTAPS);
  localparam int unsigned PHASE_W         = $clog2(MAX_FACTOR);
  localparam int unsigned WARM_W          = $clog2(HALF_SPAN + 1);
  localparam int unsigned CFG_W           = 3;
  localparam int unsigned RND_W           = ACC_W - COEF_FRAC + 1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [CFG_W-1:0] FACTOR_LOG2_RESET = CFG_W'(1);

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } psi_state_e;

endpackage

>>> sv/psi_intf.sv
`timescale 1ns / 1ps

interface psi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [psi_pkg::SAMPLE_W-1:0]  sample;
  logic                                 restart;
  logic        [3:0]                    coef_phase;
  logic        [5:0]                    coef_tap;
  logic signed [psi_pkg::COEF_W-1:0]    coef_value;

  modport source (output valid, cmd, sample, restart, coef_phase, coef_tap, coef_value,
                  input ready);
  modport sink (input valid, cmd, sample, restart, coef_phase, coef_tap, coef_value,
                output ready);
endinterface

interface psi_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [psi_pkg::SAMPLE_W-1:0] value;
  logic                                last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface psi_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [psi_pkg::CFG_W-1:0]        data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> sv/polyphase_sinc_interpolator.sv
`timescale 1ns / 1ps

// Polyphase windowed-sinc upsampler for one channel. A load beat (cmd 1) writes one
// Q2.16 tap into the 16 x 33 coefficient memory. A sample beat (cmd 0) shifts into
// the 33-deep delay line; the first 16 samples after a restart produce nothing. Every
// later sample produces 2**factor_log2 results (factor_log2 above 4 acts as 4), phase
// 0 first, last set on the final one. All phases share one 16 x 18 multiply-accumulate
// fed by a single coefficient read port, one tap per cycle; each tap passes the
// coefficient read register, the product register and the accumulator; a phase's
// result then waits in a drain state until the output register is free. The input
// is not ready while a sample is being worked on; the output register lets the last
// result wait while the next beat is taken.
module polyphase_sinc_interpolator (
  input  logic       clk_i,
  input  logic       rst_ni,
  psi_in_if.sink     in_i,
  psi_out_if.source  out_o,
  psi_cfg_if.sink    cfg_i
);

  psi_pkg::psi_state_e state_q, state_d;

  logic [psi_pkg::CFG_W-1:0]              factor_log2_q;
  logic signed [psi_pkg::SAMPLE_W-1:0]    window_q [psi_pkg::NTAPS];
  logic [psi_pkg::WARM_W-1:0]             warm_q, warm_base;
  logic [psi_pkg::PHASE_W-1:0]            phase_q, last_phase;
  logic [psi_pkg::TAP_CNT_W-1:0]          tap_cnt_q;
  logic [psi_pkg::TAP_AW-1:0]             rd_addr_q, wr_addr;

  logic signed [psi_pkg::COEF_W-1:0]      taps_mem [psi_pkg::TAP_DEPTH];
  logic signed [psi_pkg::COEF_W-1:0]      rdata_q;

  logic                                   s1_valid_q, s1_last_q;
  logic signed [psi_pkg::SAMPLE_W-1:0]    s1_win_q;
  logic                                   s2_valid_q, s2_last_q;
  logic signed [psi_pkg::PROD_W-1:0]      prod_q;
  logic signed [psi_pkg::ACC_W-1:0]       acc_q;
  logic                                   acc_done_q;

  logic                                   out_valid_q, out_last_q;
  logic signed [psi_pkg::SAMPLE_W-1:0]    out_value_q;

  logic in_accept, sample_go, load_go, load_we, emit_go;
  logic out_free, emit_now, phase_is_last, start_phase;
  logic in_ready, issue;
  logic [psi_pkg::CFG_W-1:0]              eff_log2;
  logic signed [psi_pkg::RND_W-1:0]       rnd;
  logic signed [psi_pkg::SAMPLE_W-1:0]    sat_value;

  // ---------------------------------------------------------------- decode
  assign in_accept = in_i.valid && in_ready;
  assign sample_go = in_accept && (in_i.cmd == psi_pkg::CMD_SAMPLE);
  assign load_go   = in_accept && (in_i.cmd == psi_pkg::CMD_LOAD);
  assign load_we   = load_go && (32'(in_i.coef_tap) < psi_pkg::NTAPS);

  // Row address of a tap: phase * 33 + tap.
  assign wr_addr = (psi_pkg::TAP_AW'(in_i.coef_phase) * psi_pkg::TAP_AW'(psi_pkg::NTAPS))
                 + psi_pkg::TAP_AW'(in_i.coef_tap);

  assign warm_base = in_i.restart ? '0 : warm_q;
  assign emit_go   = sample_go && (32'(warm_base) == psi_pkg::HALF_SPAN);

  assign eff_log2   = (32'(factor_log2_q) > psi_pkg::FACTOR_LOG2_MAX)
                    ? psi_pkg::CFG_W'(psi_pkg::FACTOR_LOG2_MAX) : factor_log2_q;
  assign last_phase = psi_pkg::PHASE_W'(((psi_pkg::PHASE_W + 1)'(1) << eff_log2)
                                        - (psi_pkg::PHASE_W + 1)'(1));

  assign out_free      = !out_valid_q || out_o.ready;
  assign emit_now      = (state_q == psi_pkg::ST_DRAIN) && acc_done_q && out_free;
  assign phase_is_last = (phase_q == last_phase);
  assign start_phase   = emit_go || (emit_now && !phase_is_last);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      psi_pkg::ST_IDLE: begin
        if (emit_go) state_d = psi_pkg::ST_MAC;
      end
      psi_pkg::ST_MAC: begin
        if (32'(tap_cnt_q) == psi_pkg::NTAPS - 1) state_d = psi_pkg::ST_DRAIN;
      end
      psi_pkg::ST_DRAIN: begin
        if (emit_now) state_d = phase_is_last ? psi_pkg::ST_IDLE : psi_pkg::ST_MAC;
      end
      default: state_d = psi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    case (state_q)
      psi_pkg::ST_IDLE:  in_ready = 1'b1;
      psi_pkg::ST_MAC:   issue    = 1'b1;
      psi_pkg::ST_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= psi_pkg::ST_IDLE;
      factor_log2_q <= psi_pkg::FACTOR_LOG2_RESET;
      warm_q        <= '0;
      phase_q       <= '0;
      tap_cnt_q     <= '0;
      rd_addr_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) factor_log2_q <= cfg_i.data;
      if (sample_go && (32'(warm_base) < psi_pkg::HALF_SPAN)) begin
        warm_q <= warm_base + psi_pkg::WARM_W'(1);
      end else if (sample_go) begin
        warm_q <= warm_base;
      end
      if (emit_go) begin
        phase_q   <= '0;
        rd_addr_q <= '0;
      end else if (emit_now && !phase_is_last) begin
        phase_q <= phase_q + psi_pkg::PHASE_W'(1);
      end
      if (start_phase) begin
        tap_cnt_q <= '0;
      end else if (issue) begin
        tap_cnt_q <= tap_cnt_q + psi_pkg::TAP_CNT_W'(1);
        rd_addr_q <= rd_addr_q + psi_pkg::TAP_AW'(1);
      end
    end
  end

  // The delay line rotates once per tap, so window_q[0] always holds the sample that
  // meets the tap being read; after 33 taps it is back in place for the next phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < psi_pkg::NTAPS; i++) window_q[i] <= '0;
    end else if (sample_go) begin
      for (int i = 0; i < psi_pkg::NTAPS - 1; i++) begin
        window_q[i] <= in_i.restart ? '0 : window_q[i+1];
      end
      window_q[psi_pkg::NTAPS-1] <= in_i.sample;
    end else if (issue) begin
      for (int i = 0; i < psi_pkg::NTAPS - 1; i++) window_q[i] <= window_q[i+1];
      window_q[psi_pkg::NTAPS-1] <= window_q[0];
    end
  end

  // ---------------------------------------------------------------- coefficient memory
  always_ff @(posedge clk_i) begin
    if (load_we) taps_mem[wr_addr] <= in_i.coef_value;
    if (issue) rdata_q <= taps_mem[rd_addr_q];
  end

  // ---------------------------------------------------------------- MAC pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s1_last_q  <= issue && (32'(tap_cnt_q) == psi_pkg::NTAPS - 1);
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_valid_q && s1_last_q;
      if (start_phase) begin
        acc_done_q <= 1'b0;
      end else if (s2_valid_q && s2_last_q) begin
        acc_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) s1_win_q <= window_q[0];
    if (s1_valid_q) prod_q <= s1_win_q * rdata_q;
    if (start_phase) begin
      acc_q <= '0;
    end else if (s2_valid_q) begin
      acc_q <= acc_q + psi_pkg::ACC_W'(prod_q);
    end
  end

  // Drop the 16 fraction bits, round half up, then clamp to Q1.15.
  always_comb begin
    rnd = psi_pkg::RND_W'($signed(acc_q[psi_pkg::ACC_W-1:psi_pkg::COEF_FRAC]))
        + psi_pkg::RND_W'({1'b0, acc_q[psi_pkg::COEF_FRAC-1]});
    if (rnd > psi_pkg::SAT_HI) begin
      sat_value = psi_pkg::SAMPLE_W'(psi_pkg::SAT_HI);
    end else if (rnd < psi_pkg::SAT_LO) begin
      sat_value = psi_pkg::SAMPLE_W'(psi_pkg::SAT_LO);
    end else begin
      sat_value = psi_pkg::SAMPLE_W'(rnd);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_now) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      out_value_q <= sat_value;
      out_last_q  <= phase_is_last;
    end
  end

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;
  assign out_o.last  = out_last_q;

endmodule

>>> sv/psi_checker.sv
`timescale 1ns / 1ps

module psi_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              in_cmd_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [psi_pkg::SAMPLE_W-1:0] out_value_i,
  input logic                              out_last_i,
  input logic                              cfg_ready_i
);

  // A result that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_last_i))
    else $error("stalled output beat changed");

  // A coefficient load finishes in the cycle it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == psi_pkg::CMD_LOAD) |=> in_ready_i)
    else $error("input not ready after a load beat");

  // While a result other than the final phase is on offer, more phases are still
  // pending, so no new beat may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a sample's results");

  // Results only follow a sample beat; a taken input cannot coincide with a new result
  // that was not already waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared directly after an input beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind polyphase_sinc_interpolator psi_checker u_psi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value),
  .out_last_i  (out_o.last),
  .cfg_ready_i (cfg_i.ready)
);
